// File: hw/rtl/qcwc_pkg.sv
`timescale 1ns / 1ps

package qcwc_pkg;

  localparam int TIME_IN_W = 48;
  localparam int BYTES_W = 16;
  localparam int MDS_W = 16;
  localparam int CFG_W = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_W = 32;
  localparam int PRODUCT_W = MDS_W + BYTES_W;
  localparam int DIV_STEPS = PRODUCT_W;
  localparam int STEP_W = $clog2(DIV_STEPS);
  localparam int Q_DEPTH = 2;

  localparam logic [1:0] CMD_SENT = 2'd0;
  localparam logic [1:0] CMD_ACKED = 2'd1;
  localparam logic [1:0] CMD_LOST = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_WINDOW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DATAGRAM_SIZE = 2'd2;

  localparam logic [CFG_W-1:0] INITIAL_WINDOW_RESET = 32'd12000;
  localparam logic [CFG_W-1:0] MINIMUM_WINDOW_RESET = 32'd2400;
  localparam logic [MDS_W-1:0] MAX_DATAGRAM_SIZE_RESET = 16'd1200;

  typedef enum logic [1:0] {
    OP_SENT,
    OP_ACK,
    OP_LOST,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_GROW
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic [BYTES_W-1:0]   bytes;
    logic [PRODUCT_W-1:0] product;
    logic [TIME_IN_W-1:0] sent;
    logic [TIME_IN_W-1:0] now;
    logic                 last;
  } entry_t;

  typedef struct packed {
    logic [OUT_W-1:0] window;
    logic [OUT_W-1:0] inflight;
    logic [OUT_W-1:0] threshold;
    logic             entered;
  } result_t;

endpackage

// File: hw/rtl/quic_congestion_window_control.sv
`timescale 1ns / 1ps

// NewReno congestion window control for a QUIC sender, one packet event per request.
// Requests enter a two-entry queue whenever it has room, and each result waits in an
// output register, so the input side keeps accepting while a result is held. An
// executed request reaches the output register in the cycle after it leaves the
// queue, except an ack in congestion avoidance, which is issued, then runs the 32
// steps of the one-bit-per-cycle restoring divider that forms the window growth,
// and then adds the growth to the window. The window resets to a fixed initial
// value, and writes to configuration index 0 have no effect.

module quic_congestion_window_control
  import qcwc_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int WINDOW_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [BYTES_W-1:0]     packet_bytes,
  input  logic [TIME_IN_W-1:0]   send_time,
  input  logic [TIME_IN_W-1:0]   current_time,
  input  logic                   batch_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       window_bytes,
  output logic [OUT_W-1:0]       inflight_bytes,
  output logic [OUT_W-1:0]       threshold_bytes,
  output logic                   recovery_entered,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [CFG_W-1:0] minimum_window;
  logic [MDS_W-1:0] max_datagram_size;

  logic    q_full;
  logic    q_push;
  entry_t  q_in;
  logic    q_valid;
  logic    q_pop;
  entry_t  q_head;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_window <= MINIMUM_WINDOW_RESET;
      max_datagram_size <= MAX_DATAGRAM_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MINIMUM_WINDOW:    minimum_window <= cfg_data;
        REG_MAX_DATAGRAM_SIZE: max_datagram_size <= cfg_data[MDS_W-1:0];
        default:               minimum_window <= minimum_window;
      endcase
    end
  end

  qcwc_front u_front (
    .cmd               (cmd),
    .packet_bytes      (packet_bytes),
    .send_time         (send_time),
    .current_time      (current_time),
    .batch_end         (batch_end),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .max_datagram_size (max_datagram_size),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_data            (q_in)
  );

  qcwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  qcwc_back #(
    .TIME_BITS   (TIME_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .head           (q_head),
    .q_pop          (q_pop),
    .minimum_window (minimum_window),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result         (result)
  );

  assign window_bytes = result.window;
  assign inflight_bytes = result.inflight;
  assign threshold_bytes = result.threshold;
  assign recovery_entered = result.entered;

endmodule

// File: hw/rtl/qcwc_front.sv
`timescale 1ns / 1ps

module qcwc_front
  import qcwc_pkg::*;
(
  input  logic [1:0]           cmd,
  input  logic [BYTES_W-1:0]   packet_bytes,
  input  logic [TIME_IN_W-1:0] send_time,
  input  logic [TIME_IN_W-1:0] current_time,
  input  logic                 batch_end,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MDS_W-1:0]     max_datagram_size,
  input  logic                 q_full,
  output logic                 q_push,
  output entry_t               q_data
);

  op_t op;

  always_comb begin
    unique case (cmd)
      CMD_SENT:  op = OP_SENT;
      CMD_ACKED: op = OP_ACK;
      CMD_LOST:  op = OP_LOST;
      default:   op = OP_NONE;
    endcase
  end

  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full;

  // The growth numerator is formed here so that the back end only divides.
  always_comb begin
    q_data.op = op;
    q_data.bytes = packet_bytes;
    q_data.product = PRODUCT_W'(max_datagram_size) * PRODUCT_W'(packet_bytes);
    q_data.sent = send_time;
    q_data.now = current_time;
    q_data.last = batch_end;
  end

endmodule

// File: hw/rtl/qcwc_queue.sv
`timescale 1ns / 1ps

module qcwc_queue
  import qcwc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t head
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  entry_t mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full = (count == CNT_W'(Q_DEPTH));
  assign valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/qcwc_back.sv
`timescale 1ns / 1ps

module qcwc_back
  import qcwc_pkg::*;
#(
  parameter int TIME_BITS = 48,
  parameter int WINDOW_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  entry_t           head,
  output logic             q_pop,
  input  logic [CFG_W-1:0] minimum_window,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          result
);

  localparam int W = WINDOW_BITS;
  localparam int SUMW = ((W > PRODUCT_W) ? W : PRODUCT_W) + 1;
  localparam logic [SUMW-1:0] WIN_MAX = SUMW'({W{1'b1}});

  state_t state;
  state_t state_next;

  logic [W-1:0]         window;
  logic [W-1:0]         in_flight;
  logic [W-1:0]         ssthresh;
  logic [TIME_BITS-1:0] recovery_start;
  logic [TIME_BITS-1:0] latest_lost;

  logic [W-1:0]         divisor;
  logic [W-1:0]         rem;
  logic [PRODUCT_W-1:0] quo;
  logic [STEP_W-1:0]    step;

  logic [W-1:0]         window_next;
  logic [W-1:0]         in_flight_next;
  logic [W-1:0]         ssthresh_next;
  logic [TIME_BITS-1:0] recovery_start_next;
  logic [TIME_BITS-1:0] latest_lost_next;
  logic                 entered_next;

  logic                 out_free;
  logic                 start_div;
  logic                 load_result;

  logic [TIME_BITS-1:0] sent;
  logic [TIME_BITS-1:0] now;
  logic                 after_recovery;
  logic                 sent_newer;
  logic                 lost_after_recovery;
  logic                 in_slow_start;

  logic [W:0]           flight_sum;
  logic [W-1:0]         flight_add;
  logic [W-1:0]         bytes_w;
  logic [W-1:0]         flight_sub;
  logic [PRODUCT_W-1:0] addend;
  logic [SUMW-1:0]      win_sum;
  logic [W-1:0]         grown;
  logic [W-1:0]         half;
  logic [W-1:0]         floor_w;
  logic [W-1:0]         reduced;

  logic [W:0]           trial;
  logic                 trial_ge;

  assign out_free = !out_valid || out_ready;

  assign sent = TIME_BITS'(head.sent);
  assign now = TIME_BITS'(head.now);
  assign after_recovery = sent > recovery_start;
  assign sent_newer = sent > latest_lost;
  assign lost_after_recovery = sent_newer ? after_recovery : (latest_lost > recovery_start);
  assign in_slow_start = window < ssthresh;

  assign flight_sum = {1'b0, in_flight} + (W + 1)'(head.bytes);
  assign flight_add = flight_sum[W] ? {W{1'b1}} : flight_sum[W-1:0];
  assign bytes_w = W'(head.bytes);
  assign flight_sub = (bytes_w >= in_flight) ? '0 : in_flight - bytes_w;

  assign addend = (state == ST_GROW) ? quo : PRODUCT_W'(head.bytes);
  assign win_sum = SUMW'(window) + SUMW'(addend);
  assign grown = (win_sum > WIN_MAX) ? {W{1'b1}} : W'(win_sum);

  assign half = window >> 1;
  assign floor_w = W'(minimum_window);
  assign reduced = (half > floor_w) ? half : floor_w;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, quo[PRODUCT_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_div) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == '0) begin
          state_next = ST_GROW;
        end
      end
      ST_GROW: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    start_div = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop = q_valid && out_free;
        start_div = q_pop && (head.op == OP_ACK) && after_recovery && !in_slow_start;
        load_result = q_pop && !start_div;
      end
      ST_GROW: begin
        load_result = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    window_next = window;
    in_flight_next = in_flight;
    ssthresh_next = ssthresh;
    recovery_start_next = recovery_start;
    latest_lost_next = latest_lost;
    entered_next = 1'b0;
    if (state == ST_GROW) begin
      window_next = grown;
    end else if (q_pop) begin
      unique case (head.op)
        OP_SENT: begin
          in_flight_next = flight_add;
        end
        OP_ACK: begin
          in_flight_next = flight_sub;
          if (after_recovery && in_slow_start) begin
            window_next = grown;
          end
        end
        OP_LOST: begin
          in_flight_next = flight_sub;
          if (sent_newer) begin
            latest_lost_next = sent;
          end
          if (head.last) begin
            if (lost_after_recovery) begin
              recovery_start_next = now;
              window_next = reduced;
              ssthresh_next = reduced;
              entered_next = 1'b1;
            end
            latest_lost_next = '0;
          end
        end
        default: begin
          entered_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      window <= W'(INITIAL_WINDOW_RESET);
      in_flight <= '0;
      ssthresh <= {W{1'b1}};
      recovery_start <= '0;
      latest_lost <= '0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      window <= window_next;
      in_flight <= in_flight_next;
      ssthresh <= ssthresh_next;
      recovery_start <= recovery_start_next;
      latest_lost <= latest_lost_next;
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start_div) begin
        step <= STEP_W'(DIV_STEPS - 1);
      end else if (state == ST_DIVIDE) begin
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      divisor <= (window == '0) ? W'(1) : window;
      rem <= '0;
      quo <= head.product;
    end else if (state == ST_DIVIDE) begin
      rem <= trial_ge ? W'(trial - {1'b0, divisor}) : W'(trial);
      quo <= {quo[PRODUCT_W-2:0], trial_ge};
    end
    if (load_result) begin
      result.window <= OUT_W'(window_next);
      result.inflight <= OUT_W'(in_flight_next);
      result.threshold <= OUT_W'(ssthresh_next);
      result.entered <= entered_next;
    end
  end

endmodule

// File: tb/sv/cwnd_checker.sv
`timescale 1ns / 1ps

module cwnd_checker
  import qcwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [BYTES_W-1:0]     packet_bytes,
  input  logic [TIME_IN_W-1:0]   send_time,
  input  logic [TIME_IN_W-1:0]   current_time,
  input  logic                   batch_end,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_W-1:0]       window_bytes,
  input  logic [OUT_W-1:0]       inflight_bytes,
  input  logic [OUT_W-1:0]       threshold_bytes,
  input  logic                   recovery_entered,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     mismatches,
  output int                     outstanding,
  output int                     recoveries
);

  result_t                expected_reports[$];
  logic [OUT_W-1:0]       cwnd;
  logic [OUT_W-1:0]       flight;
  logic [OUT_W-1:0]       ssthresh;
  logic [OUT_W-1:0]       min_window;
  logic [MDS_W-1:0]       datagram;
  logic [TIME_IN_W-1:0]   rec_start;
  logic [TIME_IN_W-1:0]   lost_latest;
  int                     fail_tally = 0;
  int                     recov_tally = 0;

  assign mismatches = fail_tally;
  assign recoveries = recov_tally;

  function automatic logic [OUT_W-1:0] add_sat(input logic [OUT_W-1:0] a,
                                                input logic [OUT_W-1:0] b);
    logic [OUT_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[OUT_W] ? '1 : total[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sub_sat(input logic [OUT_W-1:0] a,
                                                input logic [OUT_W-1:0] b);
    return (b >= a) ? '0 : a - b;
  endfunction

  task automatic report(input string msg);
    if (fail_tally < 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    fail_tally++;
  endtask

  task automatic advance_congestion_state(input logic [1:0] c,
                                          input logic [BYTES_W-1:0] b,
                                          input logic [TIME_IN_W-1:0] s,
                                          input logic [TIME_IN_W-1:0] n,
                                          input logic e,
                                          output result_t r);
    logic [OUT_W-1:0] divisor;
    logic [OUT_W-1:0] grow;
    logic [OUT_W-1:0] half;
    logic             entered;
    entered = 1'b0;
    case (c)
      CMD_SENT: begin
        flight = add_sat(flight, {16'd0, b});
      end
      CMD_ACKED: begin
        flight = sub_sat(flight, {16'd0, b});
        if (s > rec_start) begin
          if (cwnd < ssthresh) begin
            cwnd = add_sat(cwnd, {16'd0, b});
          end else begin
            divisor = (cwnd == '0) ? 32'd1 : cwnd;
            grow = ({16'd0, datagram} * {16'd0, b}) / divisor;
            cwnd = add_sat(cwnd, grow);
          end
        end
      end
      CMD_LOST: begin
        flight = sub_sat(flight, {16'd0, b});
        if (s > lost_latest) begin
          lost_latest = s;
        end
        if (e) begin
          if (lost_latest > rec_start) begin
            half = cwnd >> 1;
            rec_start = n;
            cwnd = (half > min_window) ? half : min_window;
            ssthresh = cwnd;
            entered = 1'b1;
          end
          lost_latest = '0;
        end
      end
      default: begin
      end
    endcase
    r.window = cwnd;
    r.inflight = flight;
    r.threshold = ssthresh;
    r.entered = entered;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (rst) begin
      cwnd = INITIAL_WINDOW_RESET;
      flight = '0;
      ssthresh = '1;
      min_window = MINIMUM_WINDOW_RESET;
      datagram = MAX_DATAGRAM_SIZE_RESET;
      rec_start = '0;
      lost_latest = '0;
      expected_reports.delete();
    end else begin
      // Writes to the initial window index have no effect in the design, so only two registers matter here.
      if (cfg_write) begin
        case (cfg_index)
          REG_MINIMUM_WINDOW: min_window = cfg_data;
          REG_MAX_DATAGRAM_SIZE: datagram = cfg_data[MDS_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report("result arrived with no request outstanding");
        end else begin
          want = expected_reports.pop_front();
          if (window_bytes !== want.window) begin
            report($sformatf("window_bytes got %0d expected %0d", window_bytes, want.window));
          end
          if (inflight_bytes !== want.inflight) begin
            report($sformatf("inflight_bytes got %0d expected %0d",
                             inflight_bytes, want.inflight));
          end
          if (threshold_bytes !== want.threshold) begin
            report($sformatf("threshold_bytes got %0d expected %0d",
                             threshold_bytes, want.threshold));
          end
          if (recovery_entered !== want.entered) begin
            report($sformatf("recovery_entered got %0b expected %0b",
                             recovery_entered, want.entered));
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_congestion_state(cmd, packet_bytes, send_time, current_time, batch_end, fresh);
        expected_reports.push_back(fresh);
        if (fresh.entered) begin
          recov_tally++;
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qcwc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_WINDOW = 2'd0;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             cmd = '0;
  logic [BYTES_W-1:0]     packet_bytes = '0;
  logic [TIME_IN_W-1:0]   send_time = '0;
  logic [TIME_IN_W-1:0]   current_time = '0;
  logic                   batch_end = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [OUT_W-1:0]       window_bytes;
  logic [OUT_W-1:0]       inflight_bytes;
  logic [OUT_W-1:0]       threshold_bytes;
  logic                   recovery_entered;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int                     fail_count;
  int                     outstanding;
  int                     recoveries;
  int                     items_offered = 0;
  int                     settings = 0;
  int                     quiet = 0;
  int                     no_gap_left = 0;
  bit                     hold_req = 1'b0;
  logic [TIME_IN_W-1:0]   clock_now = 48'd1000;
  logic [BYTES_W-1:0]     pend_bytes[$];
  logic [TIME_IN_W-1:0]   pend_sent[$];

  always #10 clk = ~clk;

  quic_congestion_window_control dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .packet_bytes(packet_bytes),
    .send_time(send_time),
    .current_time(current_time),
    .batch_end(batch_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .window_bytes(window_bytes),
    .inflight_bytes(inflight_bytes),
    .threshold_bytes(threshold_bytes),
    .recovery_entered(recovery_entered),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cwnd_checker cwnd_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .packet_bytes(packet_bytes),
    .send_time(send_time),
    .current_time(current_time),
    .batch_end(batch_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .window_bytes(window_bytes),
    .inflight_bytes(inflight_bytes),
    .threshold_bytes(threshold_bytes),
    .recovery_entered(recovery_entered),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(fail_count),
    .outstanding(outstanding),
    .recoveries(recoveries)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [BYTES_W-1:0] rand_bytes();
    int          roll;
    logic [31:0] raw;
    roll = $urandom_range(0, 9);
    raw = $urandom;
    if (roll == 0) return 16'd0;
    if (roll == 1) return 16'hFFFF;
    if (roll < 5) return raw[15:0];
    return BYTES_W'($urandom_range(40, 1500));
  endfunction

  function automatic logic [TIME_IN_W-1:0] rand_time48();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  task automatic offer(input logic [1:0] c, input logic [BYTES_W-1:0] b,
                       input logic [TIME_IN_W-1:0] s, input logic [TIME_IN_W-1:0] n,
                       input logic e);
    in_valid <= 1'b1;
    cmd <= c;
    packet_bytes <= b;
    send_time <= s;
    current_time <= n;
    batch_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_offered++;
  endtask

  task automatic send_paced(input logic [1:0] c, input logic [BYTES_W-1:0] b,
                            input logic [TIME_IN_W-1:0] s, input logic [TIME_IN_W-1:0] n,
                            input logic e);
    int g;
    offer(c, b, s, n, e);
    if (no_gap_left > 0) begin
      no_gap_left--;
    end else begin
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic cfg_wr(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic directed_events();
    int i;
    send_paced(CMD_UNUSED, 16'hFFFF, '1, '1, 1'b1);
    send_paced(CMD_SENT, 16'd0, 48'd0, 48'd0, 1'b0);
    send_paced(CMD_SENT, 16'hFFFF, '1, 48'd10, 1'b1);
    send_paced(CMD_LOST, 16'd100, 48'd5, 48'd20, 1'b0);
    send_paced(CMD_LOST, 16'd100, '1, 48'd30, 1'b0);
    send_paced(CMD_LOST, 16'd100, 48'd3, 48'd100, 1'b1);
    send_paced(CMD_ACKED, 16'd1000, 48'd50, 48'd110, 1'b0);
    send_paced(CMD_ACKED, 16'd1000, 48'd100, 48'd120, 1'b0);
    send_paced(CMD_ACKED, 16'hFFFF, 48'd101, 48'd130, 1'b0);
    send_paced(CMD_LOST, 16'd10, 48'd50, 48'd200, 1'b1);
    send_paced(CMD_LOST, 16'd10, 48'd101, 48'd0, 1'b1);
    send_paced(CMD_LOST, 16'd10, 48'd0, 48'd300, 1'b1);
    send_paced(CMD_SENT, 16'd1000, 48'd400, 48'd400, 1'b0);
    send_paced(CMD_ACKED, 16'd2000, 48'd400, 48'd410, 1'b0);
    send_paced(CMD_ACKED, 16'd0, '1, '1, 1'b0);
    send_paced(CMD_LOST, 16'hFFFF, '1, 48'd500, 1'b1);
    for (i = 0; i < 4; i++) begin
      send_paced(CMD_LOST, 16'd1, 48'd1000 + i, 48'd600 + i, 1'b1);
    end
    send_paced(CMD_SENT, 16'd1500, 48'd700, 48'd700, 1'b0);
    send_paced(CMD_UNUSED, 16'd0, 48'd0, 48'd0, 1'b0);
  endtask

  // Mostly well-formed traffic: packets are sent, then acked or reported lost in batches.
  task automatic random_traffic(input int count);
    int                   made;
    int                   roll;
    int                   pick;
    int                   k;
    int                   n;
    bit                   broken;
    logic [1:0]           c;
    logic [BYTES_W-1:0]   b;
    logic [TIME_IN_W-1:0] s;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (pend_bytes.size() > 48) begin
        roll = 50;
      end
      if (roll < 35) begin
        b = rand_bytes();
        send_paced(CMD_SENT, b, clock_now, clock_now, 1'($urandom_range(0, 1)));
        pend_bytes.push_back(b);
        pend_sent.push_back(clock_now);
        made++;
      end else if (roll < 70 && pend_bytes.size() > 0) begin
        pick = $urandom_range(0, pend_bytes.size() - 1);
        send_paced(CMD_ACKED, pend_bytes[pick], pend_sent[pick], clock_now, 1'b0);
        pend_bytes.delete(pick);
        pend_sent.delete(pick);
        made++;
      end else if (roll < 85 && pend_bytes.size() > 0) begin
        n = $urandom_range(1, 3);
        if (n > pend_bytes.size()) begin
          n = pend_bytes.size();
        end
        broken = ($urandom_range(0, 4) == 0);
        for (k = 0; k < n; k++) begin
          pick = $urandom_range(0, pend_bytes.size() - 1);
          send_paced(CMD_LOST, pend_bytes[pick], pend_sent[pick], clock_now,
                     (k == n - 1) && !broken);
          pend_bytes.delete(pick);
          pend_sent.delete(pick);
          made++;
        end
      end else begin
        c = 2'($urandom_range(0, 3));
        b = rand_bytes();
        s = rand_time48();
        send_paced(c, b, s, (c == CMD_LOST) ? clock_now : rand_time48(),
                   1'($urandom_range(0, 1)));
        made++;
      end
      clock_now = clock_now + $urandom_range(1, 500);
    end
  endtask

  initial begin : receiver
    int burst;
    int g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      burst = ($urandom_range(0, 99) < 8) ? $urandom_range(100, 250) : $urandom_range(1, 20);
      repeat (burst) @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    settings = 1;

    // Push bytes in flight up, then drain it past zero while slow start grows the window.
    for (k = 0; k < 3; k++) begin
      offer(CMD_SENT, 16'hFFFF, 48'd1, 48'd1, 1'b0);
    end
    for (k = 0; k < 4; k++) begin
      offer(CMD_ACKED, 16'hFFFF, 48'd1, 48'd2, 1'b0);
    end
    directed_events();
    drain();

    cfg_wr(REG_INITIAL_WINDOW, 32'd1);
    cfg_wr(REG_MINIMUM_WINDOW, 32'd1);
    cfg_wr(REG_MAX_DATAGRAM_SIZE, 32'd65535);
    settings++;
    hold_req = 1'b1;
    no_gap_left = 16;
    random_traffic(160);
    drain();

    cfg_wr(REG_INITIAL_WINDOW, 32'hFFFF_FFFF);
    cfg_wr(REG_MINIMUM_WINDOW, 32'hFFFF_FFFF);
    cfg_wr(REG_MAX_DATAGRAM_SIZE, 32'd1);
    settings++;
    random_traffic(160);
    drain();

    cfg_wr(REG_INITIAL_WINDOW, $urandom);
    cfg_wr(REG_MINIMUM_WINDOW, $urandom_range(1, 20000));
    cfg_wr(REG_MAX_DATAGRAM_SIZE, $urandom_range(1, 65535));
    settings++;
    random_traffic(170);
    drain();

    cfg_wr(REG_INITIAL_WINDOW, 32'd12000);
    cfg_wr(REG_MINIMUM_WINDOW, 32'd2400);
    cfg_wr(REG_MAX_DATAGRAM_SIZE, 32'd1200);
    settings++;
    clock_now = clock_now + 48'h8000_0000_0000;
    random_traffic(160);
    drain();

    repeat (40) @(posedge clk);
    $display("Summary: %0d packet events under %0d register settings, %0d recoveries entered.",
             items_offered, settings, recoveries);
    $display("Summary: flight underflow, unused commands, split loss reports.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/qcwc_pkg.sv
hw/rtl/qcwc_front.sv
hw/rtl/qcwc_queue.sv
hw/rtl/qcwc_back.sv
hw/rtl/quic_congestion_window_control.sv
tb/sv/cwnd_checker.sv
tb/sv/testbench.sv
